// File: design/uer_pkg.sv
package uer_pkg;

	// default elapsed counter width
	localparam int COUNT_BITS_DEF = 16;

	// field widths
	localparam int TRIG_W   = 10;
	localparam int TOUT_W   = 16;
	localparam int PULSE_W  = 16;
	localparam int DIST_W   = 11;
	localparam int NSENS    = 3;
	localparam int SENS_W   = 2;
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 40;

	// register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_TRIG_TICKS   = 2'd0;
	localparam logic [1:0] REG_RISE_TIMEOUT = 2'd1;
	localparam logic [1:0] REG_FIN_TIMEOUT  = 2'd2;

	// register reset values
	localparam logic [TRIG_W-1:0] TRIG_TICKS_RST   = 10'd10;
	localparam logic [TOUT_W-1:0] RISE_TIMEOUT_RST = 16'd3000;
	localparam logic [TOUT_W-1:0] FIN_TIMEOUT_RST  = 16'd6000;

	// input kinds carried on tuser
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_START = 1'b1;

	// highest sensor number in use
	localparam logic [SENS_W-1:0] SENSOR_MAX = 2'd2;

	// width/58 = (width>>1)/29 = ((width>>1) * ceil(2^21/29)) >> 21, exact below 2^15
	localparam int CM_DIV       = 58;
	localparam int DIV_SHIFT    = 21;
	localparam logic [16:0] DIV29_MUL = 17'd72316;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RISE = 2'd1,
		PH_FALL = 2'd2
	} phase_t;

	// per-item result leaving the step stage
	typedef struct packed {
		logic [NSENS-1:0]   trigger_pins;
		logic               busy_res;
		logic               result_valid;
		logic               timed_out;
		logic [PULSE_W-1:0] pulse_us;
	} res_t;

endpackage

// File: design/ultrasonic_echo_ranger.sv
// An accepted beat goes through the input, result and output registers to m_tvalid.
// Throughput: one beat per cycle unless m_tready stalls the output; the ranging state (phase,
// counters, echo history) is updated in a single step stage, so consecutive ticks need no wait.
// The distance divide is a constant-reciprocal multiply in the output stage.
// Reset (arst_n low, asynchronous): idle, counters cleared, registers at 10/3000/6000,
// no result pending.
module ultrasonic_echo_ranger #(
	parameter int COUNT_BITS = uer_pkg::COUNT_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [uer_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	// input stream
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [uer_pkg::S_DATA_W-1:0]  s_tdata,  // sensor[1:0], echo_levels[4:2], zero fill
	input  logic                          s_tuser,  // func
	// result stream
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [uer_pkg::M_DATA_W-1:0]  m_tdata   // trigger_pins[2:0], busy_res[3],
	                                                // result_valid[4], timed_out[5],
	                                                // pulse_us[21:6], distance_cm[32:22], zero fill
);
	import uer_pkg::*;

	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	// configuration registers
	logic [TRIG_W-1:0] trig_ticks_q;
	logic [TOUT_W-1:0] rise_timeout_q;
	logic [TOUT_W-1:0] fin_timeout_q;
	logic              cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trig_ticks_q   <= TRIG_TICKS_RST;
			rise_timeout_q <= RISE_TIMEOUT_RST;
			fin_timeout_q  <= FIN_TIMEOUT_RST;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				REG_TRIG_TICKS:   trig_ticks_q   <= pwdata[TRIG_W-1:0];
				REG_RISE_TIMEOUT: rise_timeout_q <= pwdata[TOUT_W-1:0];
				REG_FIN_TIMEOUT:  fin_timeout_q  <= pwdata[TOUT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_TRIG_TICKS:   prdata = 32'(trig_ticks_q);
			REG_RISE_TIMEOUT: prdata = 32'(rise_timeout_q);
			REG_FIN_TIMEOUT:  prdata = 32'(fin_timeout_q);
			default:          prdata = '0;
		endcase
	end

	// pipeline flow control
	logic valid_s1, valid_s2, m_tvalid_q;
	logic s2_load, out_load;

	assign out_load = valid_s2 && (!m_tvalid_q || m_tready);
	assign s2_load  = valid_s1 && (!valid_s2 || out_load);
	assign s_tready = !valid_s1 || s2_load;
	assign m_tvalid = m_tvalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (!valid_s2 || out_load)
				valid_s2 <= valid_s1;
			if (!m_tvalid_q || m_tready)
				m_tvalid_q <= valid_s2;
		end
	end

	// input register
	logic              func_s1;
	logic [SENS_W-1:0] sensor_s1;
	logic [NSENS-1:0]  echo_s1;

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1   <= s_tuser;
			sensor_s1 <= s_tdata[SENS_W-1:0];
			echo_s1   <= s_tdata[SENS_W+NSENS-1:SENS_W];
		end
	end

	// ranging state
	phase_t            phase_q, phase_n;
	logic [COUNT_BITS-1:0] elapsed_q, elapsed_n;
	logic [TRIG_W-1:0] pulse_left_q, pulse_left_n;
	logic [COUNT_BITS-1:0] rise_stamp_q, rise_stamp_n;
	logic              seen_rise_q, seen_rise_n;
	logic [SENS_W-1:0] active_q, active_n;
	logic [NSENS-1:0]  last_echo_q;

	// step logic: one item against the current state
	logic [SENS_W-1:0]     sel;
	logic                  cur, prev, fin, tout;
	logic [COUNT_BITS-1:0] diff;
	logic [31:0]           diff32;
	logic [PULSE_W-1:0]    width;
	res_t                  res;

	always_comb begin
		phase_n      = phase_q;
		elapsed_n    = elapsed_q;
		pulse_left_n = pulse_left_q;
		rise_stamp_n = rise_stamp_q;
		seen_rise_n  = seen_rise_q;
		active_n     = active_q;
		fin          = 1'b0;
		tout         = 1'b0;
		width        = '0;
		sel          = (active_q > SENSOR_MAX) ? '0 : active_q;
		cur          = echo_s1[sel];
		prev         = last_echo_q[sel];
		diff         = '0;
		diff32       = '0;

		if (phase_q == PH_IDLE) begin
			if (func_s1 == FUNC_START && sensor_s1 <= SENSOR_MAX) begin
				phase_n      = PH_RISE;
				elapsed_n    = '0;
				pulse_left_n = trig_ticks_q;
				rise_stamp_n = '0;
				seen_rise_n  = 1'b0;
				active_n     = sensor_s1;
			end
		end else begin
			// tick advances the counters first
			if (func_s1 == FUNC_TICK) begin
				if (elapsed_q != CNT_MAX)
					elapsed_n = elapsed_q + 1'b1;
				if (pulse_left_q != '0)
					pulse_left_n = pulse_left_q - 1'b1;
			end
			// echo edge of the active sensor
			diff   = elapsed_n - rise_stamp_q;
			diff32 = 32'(diff);
			if (cur && !prev) begin
				rise_stamp_n = elapsed_n;
				seen_rise_n  = 1'b1;
				phase_n      = PH_FALL;
			end else if (!cur && prev && seen_rise_q) begin
				fin   = 1'b1;
				width = (diff32 > 32'h0000_FFFF) ? '1 : diff32[PULSE_W-1:0];
			end
			// timeout for the phase now in force; a fall wins
			if (!fin) begin
				if (phase_n == PH_RISE && 32'(elapsed_n) > 32'(rise_timeout_q))
					tout = 1'b1;
				else if (phase_n == PH_FALL && 32'(elapsed_n) > 32'(fin_timeout_q))
					tout = 1'b1;
			end
			if (fin || tout) begin
				phase_n      = PH_IDLE;
				seen_rise_n  = 1'b0;
				pulse_left_n = '0;
			end
		end

		res.trigger_pins = (phase_n != PH_IDLE && pulse_left_n != '0 && active_n <= SENSOR_MAX)
			? (NSENS'(1) << active_n) : '0;
		res.busy_res     = (phase_n != PH_IDLE);
		res.result_valid = fin || tout;
		res.timed_out    = tout;
		res.pulse_us     = width;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			elapsed_q    <= '0;
			pulse_left_q <= '0;
			rise_stamp_q <= '0;
			seen_rise_q  <= 1'b0;
			active_q     <= '0;
			last_echo_q  <= '0;
		end else if (s2_load) begin
			phase_q      <= phase_n;
			elapsed_q    <= elapsed_n;
			pulse_left_q <= pulse_left_n;
			rise_stamp_q <= rise_stamp_n;
			seen_rise_q  <= seen_rise_n;
			active_q     <= active_n;
			last_echo_q  <= echo_s1;
		end
	end

	// result register
	res_t res_s2;

	always_ff @(posedge clk) begin
		if (s2_load)
			res_s2 <= res;
	end

	// output stage: distance by reciprocal multiply
	logic [31:0]       dist_prod;
	logic [DIST_W-1:0] dist_cm;
	logic [M_DATA_W-1:0] m_tdata_q;

	assign dist_prod = 32'(res_s2.pulse_us[PULSE_W-1:1]) * 32'(DIV29_MUL);
	assign dist_cm   = dist_prod[DIV_SHIFT+DIST_W-1:DIV_SHIFT];

	always_ff @(posedge clk) begin
		if (out_load)
			m_tdata_q <= M_DATA_W'({dist_cm, res_s2.pulse_us, res_s2.timed_out,
				res_s2.result_valid, res_s2.busy_res, res_s2.trigger_pins});
	end

	assign m_tdata = m_tdata_q;

endmodule

// File: design/uer_checker.sv
module uer_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         pready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [uer_pkg::M_DATA_W-1:0] m_tdata
);
	import uer_pkg::*;

	// a stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// a run that ends is no longer busy
	a_end_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[3])
		else $error("busy together with result_valid");

	// timeout carries a zero measurement
	a_tout_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[5] |-> m_tdata[4] && m_tdata[32:6] == '0)
		else $error("timeout with nonzero width or no result_valid");

	// no measurement figures without a result
	a_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[32:5] == '0)
		else $error("measurement fields set without result_valid");

	// at most one trigger, only during a run, and pready high
	a_trigger: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[2:0]) && (m_tdata[2:0] == '0 || m_tdata[3]) && pready)
		else $error("bad trigger drive");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
